// File: rtl/core/tgas_pkg.sv
// Shared types and constants for the tile grid aspect selector.
// No dependencies; imported by tgas_ctrl, tgas_dp and the top level.
package tgas_pkg;

  localparam int unsigned IMG_W   = 16;  // image height/width
  localparam int unsigned TOK_W   = 14;  // token bound registers
  localparam int unsigned BLK_W   = 13;  // block height/width
  localparam int unsigned OUT_W   = 19;  // target height/width
  localparam int unsigned GRID_W  = 7;   // grid columns/rows
  localparam int unsigned CFG_IDX_W = 2;

  // tokens per tile is 256: quotient is the top bits of the token count
  localparam int unsigned TOK_SHIFT = 8;

  localparam logic [TOK_W-1:0] MIN_TOKENS_RST = 14'd512;
  localparam logic [TOK_W-1:0] MAX_TOKENS_RST = 14'd3328;
  localparam logic [BLK_W-1:0] BLOCK_H_RST    = 13'd448;
  localparam logic [BLK_W-1:0] BLOCK_W_RST    = 13'd448;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_TOKENS   = 2'd0,
    CFG_MAX_TOKENS   = 2'd1,
    CFG_BLOCK_HEIGHT = 2'd2,
    CFG_BLOCK_WIDTH  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture image size
    logic prep;    // derive tile bounds, area, tie threshold; reset best
    logic scan;    // advance candidate scanner
    logic finish;  // form and present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_idle;  // all candidates issued and evaluated
  } dp_status_t;

endpackage

// File: rtl/core/tgas_ctrl.sv
// Sequencer for the tile grid aspect selector.
// Depends on tgas_pkg; drives tgas_dp through dp_cmd_t / dp_status_t.
module tgas_ctrl
  import tgas_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_idle) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |=> state_q == ST_IDLE)
    else $error("finish not followed by idle");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> state_q == ST_PREP)
    else $error("accepted start did not enter prep");

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy_o)
    else $error("busy low after load");
`endif

endmodule

// File: rtl/core/tgas_dp.sv
// Datapath: candidate grid scanner, 3-stage ratio compare pipeline, result regs.
// Depends on tgas_pkg; commanded by tgas_ctrl.
module tgas_dp
  import tgas_pkg::*;
#(
  parameter int unsigned MAX_TILES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [IMG_W-1:0]  image_height_i,
  input  logic [IMG_W-1:0]  image_width_i,
  input  logic [TOK_W-1:0]  min_tokens_i,
  input  logic [TOK_W-1:0]  max_tokens_i,
  input  logic [BLK_W-1:0]  block_height_i,
  input  logic [BLK_W-1:0]  block_width_i,
  output logic              result_valid_o,
  output logic [OUT_W-1:0]  target_height_o,
  output logic [OUT_W-1:0]  target_width_o,
  output logic [GRID_W-1:0] grid_columns_o,
  output logic [GRID_W-1:0] grid_rows_o
);

  localparam int unsigned CW   = $clog2(MAX_TILES + 1);  // tile count width
  localparam int unsigned PW   = 2 * CW;                 // c*r
  localparam int unsigned DW   = IMG_W + CW;             // w*r, c*h, distance
  localparam int unsigned LW   = DW + CW;                // cross products
  localparam int unsigned HW   = 2 * BLK_W - 1;          // half block area
  localparam int unsigned TW   = HW + CW;                // tie threshold
  localparam int unsigned AW   = 2 * IMG_W;              // image area
  localparam int unsigned CMPW = (TW > AW) ? TW : AW;
  localparam int unsigned TGW  = CW + BLK_W;

  // tiles = max(1, tokens/256 - 1), saturated
  function automatic logic [GRID_W-1:0] tiles_of(input logic [TOK_W-1:0] tok);
    logic [TOK_W-TOK_SHIFT-1:0] q;
    logic [GRID_W-1:0]          t;
    q = tok[TOK_W-1:TOK_SHIFT];
    t = (q > 1) ? GRID_W'(q) - GRID_W'(1) : GRID_W'(1);
    if (t > GRID_W'(MAX_TILES)) begin
      t = GRID_W'(MAX_TILES);
    end
    return t;
  endfunction

  // per-item
  logic [IMG_W-1:0] h_q, w_q;
  logic [AW-1:0]    area_q;
  logic [HW-1:0]    half_q;
  logic [CW-1:0]    hi_q;

  // scanner
  logic [CW-1:0] n_q, c_q, r_q;
  logic          done_q;
  logic [PW-1:0] prod;
  logic          over, hit;

  // pipeline
  logic          s1_v_q, s2_v_q;
  logic [DW-1:0] s1_wr_q, s1_ch_q;
  logic [CW-1:0] s1_c_q, s1_r_q, s2_c_q, s2_r_q;
  logic [TW-1:0] s1_thr_q, s2_thr_q;
  logic [DW-1:0] s2_d_q;

  // best so far
  logic          have_q;
  logic [CW-1:0] best_c_q, best_r_q;
  logic [DW-1:0] best_d_q;
  logic [LW-1:0] lhs, rhs;
  logic          take;

  logic [GRID_W-1:0] lo_t, hi_t;
  logic [TGW-1:0]    tgt_h, tgt_w;

  assign lo_t = tiles_of(min_tokens_i);
  assign hi_t = tiles_of(max_tokens_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_q <= image_height_i;
      w_q <= image_width_i;
    end
    if (cmd_i.prep) begin
      area_q <= AW'(h_q) * AW'(w_q);
      half_q <= HW'((2 * HW + 1)'(block_height_i) * (2 * HW + 1)'(block_width_i) >> 1);
      hi_q   <= CW'(hi_t);
    end
  end

  // scanner: c ascends, r trails as floor(n/c) by decrementing while c*r > n
  assign prod = PW'(c_q) * PW'(r_q);
  assign over = prod > PW'(n_q);
  assign hit  = prod == PW'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b1;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= 1'b0;
      s2_v_q <= s1_v_q;
      if (cmd_i.prep) begin
        done_q <= (lo_t > hi_t);
      end else if (cmd_i.scan && !done_q && !over) begin
        s1_v_q <= hit;
        if (c_q == n_q && n_q == hi_q) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      n_q <= CW'(lo_t);
      c_q <= CW'(1);
      r_q <= CW'(lo_t);
    end else if (cmd_i.scan && !done_q) begin
      if (over) begin
        r_q <= r_q - CW'(1);
      end else if (c_q == n_q) begin
        n_q <= n_q + CW'(1);
        c_q <= CW'(1);
        r_q <= n_q + CW'(1);
      end else begin
        c_q <= c_q + CW'(1);
      end
    end
  end

  // stage 1: products; stage 2: distance
  always_ff @(posedge clk_i) begin
    s1_wr_q  <= DW'(w_q) * DW'(r_q);
    s1_ch_q  <= DW'(c_q) * DW'(h_q);
    s1_c_q   <= c_q;
    s1_r_q   <= r_q;
    s1_thr_q <= TW'(half_q) * TW'(n_q);
    s2_d_q   <= (s1_wr_q > s1_ch_q) ? s1_wr_q - s1_ch_q : s1_ch_q - s1_wr_q;
    s2_c_q   <= s1_c_q;
    s2_r_q   <= s1_r_q;
    s2_thr_q <= s1_thr_q;
  end

  // stage 3: d/r vs best_d/best_r by cross multiplication
  assign lhs  = LW'(s2_d_q) * LW'(best_r_q);
  assign rhs  = LW'(best_d_q) * LW'(s2_r_q);
  assign take = !have_q || (lhs < rhs) ||
                ((lhs == rhs) && (CMPW'(area_q) > CMPW'(s2_thr_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.prep) begin
      have_q <= 1'b0;
    end else if (s2_v_q) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      best_c_q <= CW'(1);
      best_r_q <= CW'(1);
      best_d_q <= '0;
    end else if (s2_v_q && take) begin
      best_c_q <= s2_c_q;
      best_r_q <= s2_r_q;
      best_d_q <= s2_d_q;
    end
  end

  assign status_o.scan_idle = done_q && !s1_v_q && !s2_v_q;

  // result
  assign tgt_h = TGW'(best_r_q) * TGW'(block_height_i);
  assign tgt_w = TGW'(best_c_q) * TGW'(block_width_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      target_height_o <= OUT_W'(tgt_h);
      target_width_o  <= OUT_W'(tgt_w);
      grid_columns_o  <= GRID_W'(best_c_q);
      grid_rows_o     <= GRID_W'(best_r_q);
    end
  end

`ifndef NO_ASSERTIONS
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && !done_q) |-> (r_q != '0 && c_q != '0 && c_q <= n_q && n_q <= hi_q))
    else $error("scanner out of range");

  a_best_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> (best_c_q != '0 && best_r_q != '0))
    else $error("kept grid has zero dimension");
`endif

endmodule

// File: rtl/core/tile_grid_aspect_selector.sv
// Top level of the tile grid aspect selector: config registers and wiring.
// Depends on tgas_pkg, tgas_ctrl and tgas_dp.

// An item (image_height_i, image_width_i) is transferred on a rising edge with
// start_i high and busy_o low. The block then scans every tile grid whose tile
// count lies between the bounds derived from min_tokens and max_tokens, in
// ascending count and then ascending columns, and keeps the grid whose
// columns/rows ratio is nearest the image's width/height (exact integer
// cross-multiplication; ties go to the later grid when the image area exceeds
// half a block area times the tile count). One result is presented for exactly
// one cycle with result_valid_o high; the receiver cannot stall it. Sequence:
// the transfer edge loads the image, the prep state derives the tile bounds,
// then the scanner steps through each (count, columns) pair and each rows
// decrement, the compare pipeline drains and the finish state registers the
// result; result_valid_o rises as busy_o drops, and the next image can
// transfer at the edge that ends the result cycle. The default bounds give
// 1..12 tiles. The scanner loop is the limit: one candidate enters the
// compare pipeline per cycle at most, and no new image is taken while busy_o
// is high. An empty range (min tiles above max tiles) skips the scan and
// returns the 1x1 grid.
// Config: cfg_ready_o is always high; index 0 min_tokens, 1 max_tokens,
// 2 block_height, 3 block_width (low 13 bits of cfg_data_i). Write only while
// busy_o is low.
module tile_grid_aspect_selector
  import tgas_pkg::*;
#(
  parameter int unsigned MAX_TILES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [IMG_W-1:0]     image_height_i,
  input  logic [IMG_W-1:0]     image_width_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TOK_W-1:0]     cfg_data_i,
  output logic                 result_valid_o,
  output logic [OUT_W-1:0]     target_height_o,
  output logic [OUT_W-1:0]     target_width_o,
  output logic [GRID_W-1:0]    grid_columns_o,
  output logic [GRID_W-1:0]    grid_rows_o
);

  logic [TOK_W-1:0] min_tokens_q, max_tokens_q;
  logic [BLK_W-1:0] block_height_q, block_width_q;

  dp_cmd_t    cmd;
  dp_status_t status;

  // config transfers are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_tokens_q   <= MIN_TOKENS_RST;
      max_tokens_q   <= MAX_TOKENS_RST;
      block_height_q <= BLOCK_H_RST;
      block_width_q  <= BLOCK_W_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_TOKENS:   min_tokens_q   <= cfg_data_i;
        CFG_MAX_TOKENS:   max_tokens_q   <= cfg_data_i;
        CFG_BLOCK_HEIGHT: block_height_q <= cfg_data_i[BLK_W-1:0];
        CFG_BLOCK_WIDTH:  block_width_q  <= cfg_data_i[BLK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: idle -> prep -> scan (until drained) -> finish
  tgas_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // scanner, compare pipeline and result registers
  tgas_dp #(
    .MAX_TILES (MAX_TILES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .image_height_i  (image_height_i),
    .image_width_i   (image_width_i),
    .min_tokens_i    (min_tokens_q),
    .max_tokens_i    (max_tokens_q),
    .block_height_i  (block_height_q),
    .block_width_i   (block_width_q),
    .result_valid_o  (result_valid_o),
    .target_height_o (target_height_o),
    .target_width_o  (target_width_o),
    .grid_columns_o  (grid_columns_o),
    .grid_rows_o     (grid_rows_o)
  );

endmodule

// File: test/tb_tile_grid_aspect_selector.sv
// Self-checking testbench for tile_grid_aspect_selector: directed table, then random phases.
// Depends on tgas_pkg and the RTL only; expected grids come from an in-bench predictor or typed-in table rows.
module tb_tile_grid_aspect_selector;
  import tgas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_TILES   = 16;
  localparam int unsigned STALL_LIMIT = 5000;  // cycles without any transfer
  localparam int unsigned DRAIN       = 300;   // longer than the worst-case scan
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [OUT_W-1:0]  height;
    logic [OUT_W-1:0]  width;
    logic [GRID_W-1:0] cols;
    logic [GRID_W-1:0] rows;
  } grid_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_IMAGE,
    ROW_FIXED
  } row_kind_e;

  // one line of the directed table
  typedef struct packed {
    row_kind_e        kind;
    cfg_idx_e         idx;
    logic [TOK_W-1:0] data;
    logic [IMG_W-1:0] h;
    logic [IMG_W-1:0] w;
    grid_t            want;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [IMG_W-1:0]     image_height_i;
  logic [IMG_W-1:0]     image_width_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [TOK_W-1:0]     cfg_data_i;
  logic                 result_valid_o;
  logic [OUT_W-1:0]     target_height_o;
  logic [OUT_W-1:0]     target_width_o;
  logic [GRID_W-1:0]    grid_columns_o;
  logic [GRID_W-1:0]    grid_rows_o;

  // typed-in expectation travels with the item it belongs to
  logic  want_fixed;
  grid_t want_grid;

  // shadow copy of the block's registers, updated on each config transfer
  logic [TOK_W-1:0] min_tok_q = MIN_TOKENS_RST;
  logic [TOK_W-1:0] max_tok_q = MAX_TOKENS_RST;
  logic [BLK_W-1:0] blk_h_q   = BLOCK_H_RST;
  logic [BLK_W-1:0] blk_w_q   = BLOCK_W_RST;

  grid_t       grids_due[$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;

  tile_grid_aspect_selector #(
    .MAX_TILES(MAX_TILES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .image_height_i  (image_height_i),
    .image_width_i   (image_width_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .target_height_o (target_height_o),
    .target_width_o  (target_width_o),
    .grid_columns_o  (grid_columns_o),
    .grid_rows_o     (grid_rows_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // 256 tokens per tile, one tile held back, at least one, capped at MAX_TILES
  function automatic longint unsigned tile_bound(input logic [TOK_W-1:0] tokens);
    longint unsigned q;
    q = 64'(tokens) >> TOK_SHIFT;
    q = (q > 64'd1) ? q - 64'd1 : 64'd1;
    return (q > 64'(MAX_TILES)) ? 64'(MAX_TILES) : q;
  endfunction

  // Scan counts lo..hi, columns ascending; keep the grid whose c/r is nearest
  // w/h. Distances |w*r - c*h|/(h*r) are cross-multiplied so h drops out.
  // Exact ties move to the later grid only when the image area beats half a
  // block area per tile. Empty range leaves the 1x1 grid.
  function automatic grid_t pick_grid(input logic [IMG_W-1:0] img_h,
                                      input logic [IMG_W-1:0] img_w);
    longint unsigned hh, ww, bh, bw, lo, hi, area, half_blk;
    longint unsigned n, c, r, wr, ch, d, best_c, best_r, best_d, best_rr;
    bit    have;
    grid_t g;
    hh = 64'(img_h);
    ww = 64'(img_w);
    bh = 64'(blk_h_q);
    bw = 64'(blk_w_q);
    lo = tile_bound(min_tok_q);
    hi = tile_bound(max_tok_q);
    area = ww * hh;
    half_blk = (bh * bw) / 2;
    best_c = 1;
    best_r = 1;
    best_d = 0;
    best_rr = 1;
    have = 1'b0;
    for (n = lo; n <= hi; n++) begin
      for (c = 1; c <= n; c++) begin
        if (n % c != 0) continue;
        r = n / c;
        wr = ww * r;
        ch = c * hh;
        d = (wr > ch) ? wr - ch : ch - wr;
        if (!have || d * best_rr < best_d * r ||
            (d * best_rr == best_d * r && area > half_blk * n)) begin
          have = 1'b1;
          best_c = c;
          best_r = r;
          best_d = d;
          best_rr = r;
        end
      end
    end
    g.height = OUT_W'(best_r * bh);
    g.width  = OUT_W'(best_c * bw);
    g.cols   = GRID_W'(best_c);
    g.rows   = GRID_W'(best_r);
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: config shadow, expectations, result check, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_p
    bit    moved;
    grid_t got;
    grid_t exp_grid;
    moved = 1'b0;
    if (rst_ni) begin
      // result first: it always belongs to an item taken at an earlier edge
      if (result_valid_o) begin
        moved = 1'b1;
        got = {target_height_o, target_width_o, grid_columns_o, grid_rows_o};
        if (grids_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected: h=%0d w=%0d cols=%0d rows=%0d",
                     $realtime, got.height, got.width, got.cols, got.rows);
        end else begin
          exp_grid = grids_due.pop_front();
          if (got !== exp_grid) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: grid mismatch: exp h=%0d w=%0d cols=%0d rows=%0d,",
                       $realtime, exp_grid.height, exp_grid.width, exp_grid.cols,
                       exp_grid.rows, " got h=%0d w=%0d cols=%0d rows=%0d",
                       got.height, got.width, got.cols, got.rows);
          end
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_TOKENS:   min_tok_q = cfg_data_i;
          CFG_MAX_TOKENS:   max_tok_q = cfg_data_i;
          CFG_BLOCK_HEIGHT: blk_h_q   = cfg_data_i[BLK_W-1:0];
          CFG_BLOCK_WIDTH:  blk_w_q   = cfg_data_i[BLK_W-1:0];
          default: ;
        endcase
      end

      // image transfer: queue the grid it must produce
      if (start_i && !busy_o) begin
        moved = 1'b1;
        grids_due.push_back(want_fixed ? want_grid : pick_grid(image_height_i, image_width_i));
      end

      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Holds the write until a transfer; valid stays up for a following write.
  task automatic write_reg(input cfg_idx_e idx, input logic [TOK_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // With idling on, wait until the block is free and then draw a random gap,
  // so the idle cycles fall where an image could have been sent. Start stays
  // high afterwards so back-to-back items keep it asserted.
  task automatic send_image(input logic [IMG_W-1:0] h, input logic [IMG_W-1:0] w,
                            input int unsigned idle_pct, input logic fixed,
                            input grid_t want);
    cfg_valid_i <= 1'b0;
    if (idle_pct != 0) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while (busy_o);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    image_height_i <= h;
    image_width_i  <= w;
    want_fixed     <= fixed;
    want_grid      <= want;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Block is idle once every expected grid is back and busy is low.
  // Checked on the falling edge, away from the monitor's updates.
  task automatic wait_idle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (grids_due.size() != 0 || busy_o);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Mix of full-range sizes, grid-aligned sizes (to hit exact ties),
  // small sizes, and the odd zero dimension.
  task automatic rand_image(output logic [IMG_W-1:0] h, output logic [IMG_W-1:0] w);
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(19);
    if (sel < 8) begin
      h = IMG_W'($urandom);
      w = IMG_W'($urandom);
    end else if (sel < 16) begin
      k = $urandom_range(1, 4095);
      h = IMG_W'($urandom_range(1, 16) * k);
      w = IMG_W'($urandom_range(1, 16) * k);
    end else if (sel < 19) begin
      h = IMG_W'($urandom_range(1, 64));
      w = IMG_W'($urandom_range(1, 64));
    end else if ($urandom_range(1) != 0) begin
      h = '0;
      w = IMG_W'($urandom);
    end else begin
      h = IMG_W'($urandom);
      w = '0;
    end
  endtask

  function automatic logic [TOK_W-1:0] rand_tokens();
    return ($urandom_range(3) == 0) ? TOK_W'($urandom_range(0, 16383))
                                    : TOK_W'($urandom_range(0, 4600));
  endfunction

  // small blocks make the tie rule go both ways; full range exercises masking
  function automatic logic [TOK_W-1:0] rand_block();
    int unsigned sel;
    sel = $urandom_range(3);
    if (sel == 0) return TOK_W'($urandom_range(0, 16383));
    if (sel == 1) return TOK_W'($urandom_range(1, 64));
    return TOK_W'($urandom_range(1, 4096));
  endfunction

  function automatic plan_row_t cfg_row(input cfg_idx_e idx, input int unsigned data);
    plan_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = TOK_W'(data);
    return row;
  endfunction

  function automatic plan_row_t image_row(input int unsigned h, input int unsigned w);
    plan_row_t row;
    row = '0;
    row.kind = ROW_IMAGE;
    row.h    = IMG_W'(h);
    row.w    = IMG_W'(w);
    return row;
  endfunction

  function automatic plan_row_t fixed_row(input int unsigned h, input int unsigned w,
                                          input int unsigned th, input int unsigned tw,
                                          input int unsigned cols, input int unsigned rows);
    plan_row_t row;
    row = image_row(h, w);
    row.kind = ROW_FIXED;
    row.want = {OUT_W'(th), OUT_W'(tw), GRID_W'(cols), GRID_W'(rows)};
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim_p
    plan_row_t        plan[$];
    plan_row_t        row;
    bit               cfg_open;
    logic [IMG_W-1:0] h;
    logic [IMG_W-1:0] w;
    int unsigned      p;
    int unsigned      i;
    int unsigned      pct;

    start_i        <= 1'b0;
    image_height_i <= '0;
    image_width_i  <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_MIN_TOKENS;
    cfg_data_i     <= '0;
    want_fixed     <= 1'b0;
    want_grid      <= '0;
    rst_ni         <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: 1..12 tiles, 448x448 blocks; square image stays 1x1
    plan.push_back(fixed_row(448, 448, 448, 448, 1, 1));
    plan.push_back(image_row(1, 1));
    plan.push_back(image_row(65535, 65535));
    plan.push_back(image_row(1, 65535));
    plan.push_back(image_row(65535, 1));
    plan.push_back(image_row(0, 100));      // zero height: every grid ties
    plan.push_back(image_row(100, 0));      // zero width
    plan.push_back(image_row(0, 0));
    plan.push_back(image_row(448, 896));
    // empty tile range, zero block height, widest block
    plan.push_back(cfg_row(CFG_MIN_TOKENS, 16383));
    plan.push_back(cfg_row(CFG_MAX_TOKENS, 0));
    plan.push_back(cfg_row(CFG_BLOCK_HEIGHT, 0));
    plan.push_back(cfg_row(CFG_BLOCK_WIDTH, 8191));
    plan.push_back(fixed_row(300, 500, 0, 8191, 1, 1));
    // bounds under 512 tokens give one tile; bit 13 of block data is dropped
    plan.push_back(cfg_row(CFG_MIN_TOKENS, 0));
    plan.push_back(cfg_row(CFG_BLOCK_HEIGHT, 16383));
    plan.push_back(cfg_row(CFG_BLOCK_WIDTH, 0));
    plan.push_back(fixed_row(65535, 65535, 8191, 0, 1, 1));
    // exactly MAX_TILES tiles, unit blocks
    plan.push_back(cfg_row(CFG_MIN_TOKENS, 16383));
    plan.push_back(cfg_row(CFG_MAX_TOKENS, 16383));
    plan.push_back(cfg_row(CFG_BLOCK_HEIGHT, 1));
    plan.push_back(cfg_row(CFG_BLOCK_WIDTH, 1));
    plan.push_back(fixed_row(1, 65535, 1, 16, 16, 1));
    plan.push_back(fixed_row(65535, 1, 16, 1, 1, 16));
    plan.push_back(image_row(0, 0));
    plan.push_back(image_row(16, 16));
    // 511 and 767 tokens both give one tile; 767 is just under two tiles
    plan.push_back(cfg_row(CFG_MIN_TOKENS, 511));
    plan.push_back(cfg_row(CFG_MAX_TOKENS, 767));
    plan.push_back(image_row(1000, 3000));
    // full range 1..MAX_TILES, 4096x4096 blocks
    plan.push_back(cfg_row(CFG_MIN_TOKENS, 0));
    plan.push_back(cfg_row(CFG_MAX_TOKENS, 16383));
    plan.push_back(cfg_row(CFG_BLOCK_HEIGHT, 4096));
    plan.push_back(cfg_row(CFG_BLOCK_WIDTH, 4096));
    plan.push_back(image_row(1080, 1920));
    plan.push_back(image_row(65535, 65535));
    plan.push_back(image_row(3, 4));
    // 3..7 tiles, lopsided blocks
    plan.push_back(cfg_row(CFG_MIN_TOKENS, 1024));
    plan.push_back(cfg_row(CFG_MAX_TOKENS, 2048));
    plan.push_back(cfg_row(CFG_BLOCK_HEIGHT, 1));
    plan.push_back(cfg_row(CFG_BLOCK_WIDTH, 8191));
    plan.push_back(image_row(2, 6));
    plan.push_back(image_row(777, 12345));

    cfg_open = 1'b0;
    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) wait_idle();
        cfg_open = 1'b1;
        write_reg(row.idx, row.data);
      end else begin
        cfg_open = 1'b0;
        send_image(row.h, row.w, 0, row.kind == ROW_FIXED, row.want);
      end
    end

    // random phases: fresh settings each, sender idling cycles 0 / 65 / 12 %
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == 0) begin
        write_reg(CFG_MIN_TOKENS, MIN_TOKENS_RST);
        write_reg(CFG_MAX_TOKENS, MAX_TOKENS_RST);
        write_reg(CFG_BLOCK_HEIGHT, TOK_W'(BLOCK_H_RST));
        write_reg(CFG_BLOCK_WIDTH, TOK_W'(BLOCK_W_RST));
      end else if (p == 1) begin
        write_reg(CFG_MIN_TOKENS, TOK_W'(0));
        write_reg(CFG_MAX_TOKENS, TOK_W'(16383));
        write_reg(CFG_BLOCK_HEIGHT, TOK_W'($urandom_range(1, 4096)));
        write_reg(CFG_BLOCK_WIDTH, TOK_W'($urandom_range(1, 4096)));
      end else begin
        write_reg(CFG_MIN_TOKENS, rand_tokens());
        write_reg(CFG_MAX_TOKENS, rand_tokens());
        write_reg(CFG_BLOCK_HEIGHT, rand_block());
        write_reg(CFG_BLOCK_WIDTH, rand_block());
      end
      pct = (p % 3 == 1) ? 65 : ((p % 3 == 2) ? 12 : 0);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        rand_image(h, w);
        send_image(h, w, pct, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
    if (grids_due.size() != 0)
      $display("%0d expected grids never arrived", grids_due.size());
    if (mismatches == 0 && grids_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
